>>> rtl/fct_pkg.sv
// Shared types and constants for the link table engine.
`timescale 1ns / 1ps

package fct_pkg;

   // Field widths
   localparam int OPCODE_W = 3;
   localparam int BLOCK_W  = 32;
   localparam int COUNT_W  = 12;
   localparam int STATUS_W = 2;
   localparam int DSTART_W = 12;
   localparam int TOTAL_W  = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam int NUM_BLOCKS_DEFAULT = 4096;

   // Link codes
   localparam logic [BLOCK_W-1:0] LINK_FREE = '0;
   localparam logic [BLOCK_W-1:0] LINK_END  = '1;

   // Operations
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_WALK  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TRUNC = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ  = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_CHAIN_END = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'd1;

   // Register reset values
   localparam logic [DSTART_W-1:0] DATA_START_RST    = 12'd4;
   localparam logic [TOTAL_W-1:0]  BLOCKS_IN_USE_RST = 13'd4096;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_ALLOC_LINK,
      ST_TRAV,
      ST_FREE,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

>>> rtl/fct_link_ram.sv
// Link table storage: one write port, one registered read port (read-first).
`timescale 1ns / 1ps

module fct_link_ram #(
   parameter int DEPTH  = fct_pkg::NUM_BLOCKS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [fct_pkg::BLOCK_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [fct_pkg::BLOCK_W-1:0]  rd_data
);
   import fct_pkg::*;

   logic [BLOCK_W-1:0] mem [DEPTH];
   logic [BLOCK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fat_chain_table_engine.sv
// Top level: link table engine with sequencer around a shared table port.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  req     | in        | req_valid/req_stall  | opcode, block, count, value
//  rsp     | out       | rsp_valid/rsp_stall  | result_block, status
//  csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// After reset a clearing pass writes every entry to free, with req_stall high. One
// item at a time; the table port (one read, one write a cycle) sets the rate: allocate
// scans entries for a free one, free and truncate follow the chain, walk follows up
// to count links, and write and read touch a single entry; a truncate may walk far
// and then free a long tail. The result sits in an output register; a stalled rsp
// holds the next finished item in the done state until the register frees up.
`timescale 1ns / 1ps

module fat_chain_table_engine #(
   parameter int NUM_BLOCKS = fct_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fct_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [fct_pkg::BLOCK_W-1:0]    req_block,
   input  logic [fct_pkg::COUNT_W-1:0]    req_count,
   input  logic [fct_pkg::BLOCK_W-1:0]    req_value,
   // response
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fct_pkg::BLOCK_W-1:0]    rsp_result_block,
   output logic [fct_pkg::STATUS_W-1:0]   rsp_status,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [fct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fct_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import fct_pkg::*;

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int PTR_W = $clog2(NUM_BLOCKS + 1);
   localparam logic [BLOCK_W-1:0] NB_LINK = BLOCK_W'(NUM_BLOCKS);
   localparam logic [PTR_W-1:0]   PTR_MAX = PTR_W'(NUM_BLOCKS);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(NUM_BLOCKS - 1);

   // ---------------------------------------------------------------- registers
   state_type            state_ff, state_in;
   logic [DSTART_W-1:0]  data_start_ff;
   logic [TOTAL_W-1:0]   blocks_in_use_ff;

   logic [OPCODE_W-1:0]  op_ff, op_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   k_ff, k_in;
   logic [BLOCK_W-1:0]   cur_ff, cur_in;
   logic                 step_ff, step_in;    // cur comes from last table read
   logic                 pend_ff, pend_in;    // scan read in flight
   logic [PTR_W-1:0]     ptr_ff, ptr_in;      // clear/scan address, free step count
   logic [BLOCK_W-1:0]   res_ff, res_in;
   logic [STATUS_W-1:0]  st_ff, st_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]   rsp_block_ff, rsp_block_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // ---------------------------------------------------------------- table port
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [BLOCK_W-1:0]   mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;
   logic [BLOCK_W-1:0]   mem_rdata;

   fct_link_ram #(
      .DEPTH  (NUM_BLOCKS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ---------------------------------------------------------------- conditions
   logic                 req_take;
   logic                 out_free;
   logic [BLOCK_W-1:0]   limit_w;
   logic                 start_past_limit;
   logic [BLOCK_W-1:0]   cur_w;
   logic [IDX_W-1:0]     cur_idx;
   logic                 usable_w;
   logic                 k_hit;
   logic                 found_w;
   logic [PTR_W-1:0]     found_ptr;
   logic                 scan_end;
   logic                 blk_in_range;
   logic                 req_in_range;
   logic                 need_link;

   assign req_take = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // scan limit is min(blocks in use, NUM_BLOCKS)
   assign limit_w = (BLOCK_W'(blocks_in_use_ff) < NB_LINK) ?
                    BLOCK_W'(blocks_in_use_ff) : NB_LINK;
   assign start_past_limit = BLOCK_W'(data_start_ff) >= limit_w;

   // current chain position: freshly read entry right after a read
   assign cur_w    = step_ff ? mem_rdata : cur_ff;
   assign cur_idx  = cur_w[IDX_W-1:0];
   assign usable_w = (cur_w != LINK_FREE) && (cur_w != LINK_END) && (cur_w < NB_LINK);
   assign k_hit    = (k_ff == cnt_ff);

   assign found_w   = pend_ff && (mem_rdata == LINK_FREE);
   assign found_ptr = PTR_W'(ptr_ff - PTR_W'(1));
   assign scan_end  = BLOCK_W'(ptr_ff) >= limit_w;

   assign blk_in_range = blk_ff < NB_LINK;
   assign req_in_range = req_block < NB_LINK;
   assign need_link    = blk_in_range && (blk_ff != BLOCK_W'(found_ptr));

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == PTR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_opcode)
                  OP_ALLOC: state_in = start_past_limit ? ST_DONE : ST_ALLOC;
                  OP_FREE:  state_in = ST_FREE;
                  OP_WALK:  state_in = ST_TRAV;
                  OP_TRUNC: state_in = (req_count == '0) ? ST_FREE : ST_TRAV;
                  OP_READ:  state_in = req_in_range ? ST_READ : ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_ALLOC: begin
            if (found_w) state_in = need_link ? ST_ALLOC_LINK : ST_DONE;
            else if (scan_end) state_in = ST_DONE;
         end
         ST_ALLOC_LINK: state_in = ST_DONE;
         ST_TRAV: begin
            if (op_ff == OP_WALK) begin
               if (k_hit || !usable_w) state_in = ST_DONE;
            end else begin
               if (!usable_w) state_in = ST_DONE;
               else if (k_hit) state_in = ST_FREE;
            end
         end
         ST_FREE: begin
            if (!usable_w || (ptr_ff == PTR_MAX)) state_in = ST_DONE;
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      op_in   = op_ff;
      blk_in  = blk_ff;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      cur_in  = cur_ff;
      step_in = 1'b0;
      pend_in = 1'b0;
      ptr_in  = ptr_ff;
      res_in  = res_ff;
      st_in   = st_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = LINK_FREE;
      mem_raddr = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[IDX_W-1:0];
            ptr_in    = PTR_W'(ptr_ff + PTR_W'(1));
         end
         ST_IDLE: begin
            op_in  = req_opcode;
            blk_in = req_block;
            cnt_in = req_count;
            cur_in = req_block;
            res_in = LINK_FREE;
            st_in  = STAT_OK;
            ptr_in = '0;
            if (req_take) begin
               unique case (req_opcode)
                  OP_ALLOC: begin
                     if (start_past_limit) st_in = STAT_NO_FREE;
                     else ptr_in = PTR_W'(data_start_ff);
                  end
                  OP_WALK:  k_in = '0;
                  OP_TRUNC: begin
                     k_in = COUNT_W'(1);
                     if (req_count == '0) res_in = LINK_END;
                  end
                  OP_WRITE: begin
                     mem_we    = req_in_range;
                     mem_waddr = req_block[IDX_W-1:0];
                     mem_wdata = req_value;
                  end
                  OP_READ:  mem_raddr = req_block[IDX_W-1:0];
                  default: ;
               endcase
            end
         end
         ST_ALLOC: begin
            if (found_w) begin
               // claim the free entry as a chain end
               mem_we    = 1'b1;
               mem_waddr = found_ptr[IDX_W-1:0];
               mem_wdata = LINK_END;
               res_in    = BLOCK_W'(found_ptr);
            end else if (scan_end) begin
               st_in = STAT_NO_FREE;
            end else begin
               mem_raddr = ptr_ff[IDX_W-1:0];
               ptr_in    = PTR_W'(ptr_ff + PTR_W'(1));
               pend_in   = 1'b1;
            end
         end
         ST_ALLOC_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = blk_ff[IDX_W-1:0];
            mem_wdata = res_ff;
         end
         ST_TRAV: begin
            cur_in = cur_w;
            if (op_ff == OP_WALK) begin
               if (k_hit) begin
                  res_in = cur_w;
               end else if (!usable_w) begin
                  res_in = LINK_END;
                  st_in  = STAT_CHAIN_END;
               end else begin
                  mem_raddr = cur_idx;
                  step_in   = 1'b1;
                  k_in      = COUNT_W'(k_ff + COUNT_W'(1));
               end
            end else begin
               if (!usable_w) begin
                  res_in = LINK_END;
                  st_in  = STAT_CHAIN_END;
               end else if (k_hit) begin
                  // cut: mark last kept block as end, free what followed it
                  mem_raddr = cur_idx;
                  mem_we    = 1'b1;
                  mem_waddr = cur_idx;
                  mem_wdata = LINK_END;
                  res_in    = cur_w;
                  step_in   = 1'b1;
                  ptr_in    = '0;
               end else begin
                  mem_raddr = cur_idx;
                  step_in   = 1'b1;
                  k_in      = COUNT_W'(k_ff + COUNT_W'(1));
               end
            end
         end
         ST_FREE: begin
            cur_in = cur_w;
            if (usable_w && (ptr_ff != PTR_MAX)) begin
               mem_raddr = cur_idx;
               mem_we    = 1'b1;
               mem_waddr = cur_idx;
               mem_wdata = LINK_FREE;
               step_in   = 1'b1;
               ptr_in    = PTR_W'(ptr_ff + PTR_W'(1));
            end
         end
         ST_READ: begin
            res_in = mem_rdata;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_block_in  = res_ff;
               rsp_status_in = st_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         ptr_ff           <= '0;
         step_ff          <= 1'b0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         data_start_ff    <= DATA_START_RST;
         blocks_in_use_ff <= BLOCKS_IN_USE_RST;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DATA_START:    data_start_ff    <= csr_write_data[DSTART_W-1:0];
               CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_write_data[TOTAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      cur_ff        <= cur_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_status       = rsp_status_ff;

   // ---------------------------------------------------------------- checks
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (BLOCK_W'(mem_waddr) < NB_LINK))
      else $error("table write outside the table");

   a_chain_end_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_CHAIN_END)) |-> (rsp_result_block == LINK_END))
      else $error("broken chain reported without end code");

   a_no_free_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_NO_FREE)) |-> (rsp_result_block == LINK_FREE))
      else $error("failed allocate returned a block");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

endmodule

>>> tb/fat_chain_table_engine_test.sv
// Self-checking bench for the link table engine: directed script, then random phases.
`timescale 1ns / 1ps

module fat_chain_table_engine_test;
   import fct_pkg::*;

   localparam int TABLE_DEPTH = NUM_BLOCKS_DEFAULT;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 19;

   // opcodes the block treats as no-ops
   localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [BLOCK_W-1:0]  block;
      logic [COUNT_W-1:0]  count;
      logic [BLOCK_W-1:0]  value;
   } table_req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  result_block;
      logic [STATUS_W-1:0] status;
   } table_answer_type;

   // typed = 1: the answer column is the expectation; else the table predictor decides
   typedef struct packed {
      table_req_type    q;
      logic             typed;
      table_answer_type want;
   } script_row_type;

   localparam int SCRIPT_LEN = 26;

   // Directed script, reset config (data_start 4, 4096 blocks in use)
   script_row_type script [SCRIPT_LEN] = '{
      // fresh table reads as free at both ends
      '{'{OP_READ,  32'd0,    12'd0,    32'd0},        1'b1, '{32'd0, STAT_OK}},
      '{'{OP_READ,  32'd4095, 12'd0,    32'd0},        1'b1, '{32'd0, STAT_OK}},
      // build chain 4 -> 5 -> 6
      '{'{OP_ALLOC, LINK_END, 12'd0,    32'd0},        1'b1, '{32'd4, STAT_OK}},
      '{'{OP_ALLOC, 32'd4,    12'd0,    32'd0},        1'b1, '{32'd5, STAT_OK}},
      '{'{OP_ALLOC, 32'd5,    12'd0,    32'd0},        1'b1, '{32'd6, STAT_OK}},
      // walk: zero count, mid chain, past the end
      '{'{OP_WALK,  32'd4,    12'd0,    32'd0},        1'b1, '{32'd4, STAT_OK}},
      '{'{OP_WALK,  32'd4,    12'd2,    32'd0},        1'b0, '0},
      '{'{OP_WALK,  32'd4,    12'hFFF,  32'd0},        1'b1, '{LINK_END, STAT_CHAIN_END}},
      '{'{OP_READ,  32'd6,    12'd0,    32'd0},        1'b1, '{LINK_END, STAT_OK}},
      // truncate to one block, then ask for more than is left
      '{'{OP_TRUNC, 32'd4,    12'd1,    32'd0},        1'b0, '0},
      '{'{OP_TRUNC, 32'd4,    12'd2,    32'd0},        1'b1, '{LINK_END, STAT_CHAIN_END}},
      '{'{OP_TRUNC, LINK_END, 12'hFFF,  32'd0},        1'b1, '{LINK_END, STAT_CHAIN_END}},
      // entry writes/reads, in and out of range
      '{'{OP_WRITE, 32'd4095, 12'd0,    LINK_END},     1'b1, '{32'd0, STAT_OK}},
      '{'{OP_WRITE, LINK_END, 12'd0,    32'hDEADBEEF}, 1'b1, '{32'd0, STAT_OK}},
      '{'{OP_READ,  LINK_END, 12'd0,    32'd0},        1'b1, '{32'd0, STAT_OK}},
      '{'{OP_READ,  32'd4096, 12'd0,    32'd0},        1'b1, '{32'd0, STAT_OK}},
      // two-entry loop 100 <-> 4095, walked the full count, then freed
      '{'{OP_WRITE, 32'd100,  12'd0,    32'd4095},     1'b1, '{32'd0, STAT_OK}},
      '{'{OP_WRITE, 32'd4095, 12'd0,    32'd100},      1'b1, '{32'd0, STAT_OK}},
      '{'{OP_WALK,  32'd100,  12'hFFF,  32'd0},        1'b0, '0},
      '{'{OP_FREE,  32'd100,  12'd0,    32'd0},        1'b1, '{32'd0, STAT_OK}},
      // truncate to zero blocks frees the whole chain
      '{'{OP_TRUNC, 32'd4,    12'd0,    32'd0},        1'b1, '{LINK_END, STAT_OK}},
      // unused opcodes
      '{'{OP_SPARE6, 32'd5,   12'd3,    32'd9},        1'b1, '{32'd0, STAT_OK}},
      '{'{OP_SPARE7, LINK_END, 12'hFFF, '1},           1'b1, '{32'd0, STAT_OK}},
      // one-step walk onto an out-of-range link returns that link
      '{'{OP_WRITE, 32'd7,    12'd0,    32'h80000000}, 1'b1, '{32'd0, STAT_OK}},
      '{'{OP_WALK,  32'd7,    12'd1,    32'd0},        1'b0, '0},
      // allocate that lands on its own link block: no link write
      '{'{OP_ALLOC, 32'd4,    12'd0,    32'd0},        1'b0, '0}
   };

   // per-phase config and idling odds (percent); last phase runs without idling
   int phase_start [PHASES] = '{1, 4095, 4095, 20, 4, 0};
   int phase_total [PHASES] = '{8, 4096, 8, 200, 4096, 0};
   int phase_gap   [PHASES] = '{30, 15, 0, 40, 20, 0};
   int phase_stall [PHASES] = '{10, 20, 0, 15, 8, 0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OPCODE_W-1:0]   req_opcode = '0;
   logic [BLOCK_W-1:0]    req_block = '0;
   logic [COUNT_W-1:0]    req_count = '0;
   logic [BLOCK_W-1:0]    req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BLOCK_W-1:0]    rsp_result_block;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // predictor state: shadow table and registers
   logic [BLOCK_W-1:0]  link_tbl [TABLE_DEPTH];
   logic [DSTART_W-1:0] cfg_data_start = DATA_START_RST;
   logic [TOTAL_W-1:0]  cfg_total = BLOCKS_IN_USE_RST;

   table_answer_type    answer_q [$];     // answers owed by the block, oldest first
   logic [BLOCK_W-1:0]  live_blocks [$];  // recent allocations, used to aim stimulus
   logic [BLOCK_W-1:0]  last_alloc = LINK_END;
   int                  mismatch_count = 0;
   int                  gap_odds = 25;
   int                  stall_odds = 10;

   fat_chain_table_engine #(.NUM_BLOCKS(TABLE_DEPTH)) dut (.*);

   always #5 clock = ~clock;

   // --- table predictor -----------------------------------------------------

   function automatic bit is_link(logic [BLOCK_W-1:0] v);
      return v != LINK_FREE && v != LINK_END && v < 32'(TABLE_DEPTH);
   endfunction

   // clears entries along a chain; bounded so a loop cannot hang it
   function automatic void clear_chain(logic [BLOCK_W-1:0] start);
      logic [BLOCK_W-1:0] cur;
      logic [BLOCK_W-1:0] nxt;
      int                 steps;
      cur = start;
      steps = 0;
      while (is_link(cur) && steps < TABLE_DEPTH) begin
         nxt = link_tbl[cur];
         link_tbl[cur] = LINK_FREE;
         cur = nxt;
         steps++;
      end
   endfunction

   // applies one item to the shadow table and returns the answer it earns
   function automatic table_answer_type table_op_answer(table_req_type q);
      table_answer_type   a;
      logic [BLOCK_W-1:0] cur;
      logic [BLOCK_W-1:0] rest;
      int                 limit;
      int                 slot;
      bit                 ok;
      a = '{LINK_FREE, STAT_OK};
      case (q.opcode)
         OP_ALLOC: begin
            // first fit from data_start below min(blocks in use, depth)
            limit = (int'(cfg_total) < TABLE_DEPTH) ? int'(cfg_total) : TABLE_DEPTH;
            slot = -1;
            for (int i = int'(cfg_data_start); i < limit; i++) begin
               if (link_tbl[i] == LINK_FREE) begin
                  slot = i;
                  break;
               end
            end
            if (slot < 0) begin
               a.status = STAT_NO_FREE;
            end else begin
               link_tbl[slot] = LINK_END;
               if (q.block < 32'(TABLE_DEPTH) && q.block != 32'(slot))
                  link_tbl[q.block] = 32'(slot);
               a.result_block = 32'(slot);
            end
         end
         OP_FREE: begin
            clear_chain(q.block);
         end
         OP_WALK: begin
            cur = q.block;
            for (int k = 0; k < int'(q.count); k++) begin
               if (!is_link(cur)) begin
                  a.status = STAT_CHAIN_END;
                  break;
               end
               cur = link_tbl[cur];
            end
            a.result_block = (a.status == STAT_OK) ? cur : LINK_END;
         end
         OP_TRUNC: begin
            if (q.count == 0) begin
               clear_chain(q.block);
               a.result_block = LINK_END;
            end else begin
               cur = q.block;
               ok = is_link(cur);
               for (int k = 1; ok && k < int'(q.count); k++) begin
                  cur = link_tbl[cur];
                  ok = is_link(cur);
               end
               if (ok) begin
                  // cut after the last kept block, then free the tail
                  rest = link_tbl[cur];
                  link_tbl[cur] = LINK_END;
                  clear_chain(rest);
                  a.result_block = cur;
               end else begin
                  a.result_block = LINK_END;
                  a.status = STAT_CHAIN_END;
               end
            end
         end
         OP_WRITE: begin
            if (q.block < 32'(TABLE_DEPTH))
               link_tbl[q.block] = q.value;
         end
         OP_READ: begin
            if (q.block < 32'(TABLE_DEPTH))
               a.result_block = link_tbl[q.block];
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   // --- stimulus helpers ------------------------------------------------------

   // mostly live blocks and small indexes, some "none", a little noise
   function automatic logic [BLOCK_W-1:0] pick_block();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60 && live_blocks.size() != 0)
         return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      if (r < 80)
         return 32'($urandom_range(0, 63));
      if (r < 90)
         return LINK_END;
      return $urandom();
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Presents one item, holds it until accepted, then books its answer.
   // Called at a rising edge; an optional gap drops valid first.
   task automatic send_item(input table_req_type q, input logic typed,
                            input table_answer_type want);
      table_answer_type a;
      if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= q.opcode;
      req_block  <= q.block;
      req_count  <= q.count;
      req_value  <= q.value;
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      a = table_op_answer(q);
      answer_q.push_back(typed ? want : a);
      if (q.opcode == OP_ALLOC && a.status == STAT_OK) begin
         last_alloc = a.result_block;
         live_blocks.push_back(a.result_block);
         if (live_blocks.size() > 16)
            void'(live_blocks.pop_front());
      end
   endtask

   // one register write, then a quiet edge so back-to-back calls never collide
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DATA_START)
         cfg_data_start = data[DSTART_W-1:0];
      else
         cfg_total = data[TOTAL_W-1:0];
      @(posedge clock);
   endtask

   // --- result side -----------------------------------------------------------

   // rsp backpressure in random bursts; odds set per phase
   initial begin : rsp_backpressure
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted item against the oldest owed answer
   always @(posedge clock) begin : check_results
      table_answer_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (answer_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected item: block %h status %0d",
                                    rsp_result_block, rsp_status));
         end else begin
            want = answer_q.pop_front();
            if (rsp_result_block !== want.result_block)
               flag_mismatch($sformatf("result_block %h, want %h",
                                       rsp_result_block, want.result_block));
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
         end
      end
   end

   // --- watchdog ----------------------------------------------------------------

   // worst case is every item walking the whole table twice, plus idling; 4x margin
   initial begin : watchdog
      #60_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // --- main sequence -----------------------------------------------------------

   initial begin : main_seq
      table_req_type q;
      int            r;
      int            ds;
      int            tot;
      for (int i = 0; i < TABLE_DEPTH; i++)
         link_tbl[i] = LINK_FREE;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the clearing pass after reset shows up as req_stall; send_item waits it out

      for (int i = 0; i < SCRIPT_LEN; i++)
         send_item(script[i].q, script[i].typed, script[i].want);

      for (int p = 0; p < PHASES; p++) begin
         // drain: sender holds off until every owed answer is back
         req_valid <= 1'b0;
         while (answer_q.size() != 0) @(posedge clock);
         repeat (8) @(posedge clock);

         ds  = phase_start[p];
         tot = phase_total[p];
         if (p == PHASES - 1) begin
            ds  = $urandom_range(1, 64);
            tot = $urandom_range(8, TABLE_DEPTH);
         end
         write_csr(CSR_DATA_START, CSR_DATA_W'(ds));
         write_csr(CSR_BLOCKS_IN_USE, CSR_DATA_W'(tot));
         gap_odds   = phase_gap[p];
         stall_odds = phase_stall[p];

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // counts mostly short; a few go the full range
            r = $urandom_range(0, 99);
            q.count = (r < 70) ? COUNT_W'($urandom_range(0, 5)) :
                      (r < 90) ? COUNT_W'($urandom_range(0, 40)) : COUNT_W'($urandom());
            r = $urandom_range(0, 99);
            q.value = (r < 50) ? pick_block() : (r < 65) ? LINK_END :
                      (r < 75) ? LINK_FREE : $urandom();
            q.block = pick_block();
            r = $urandom_range(0, 99);
            if (r < 30) begin
               q.opcode = OP_ALLOC;
               // extend the current chain most of the time
               if ($urandom_range(0, 99) < 55)
                  q.block = last_alloc;
            end else if (r < 40) begin
               q.opcode = OP_FREE;
            end else if (r < 60) begin
               q.opcode = OP_WALK;
            end else if (r < 75) begin
               q.opcode = OP_TRUNC;
            end else if (r < 87) begin
               q.opcode = OP_WRITE;
            end else if (r < 97) begin
               q.opcode = OP_READ;
            end else begin
               q.opcode = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
            end
            send_item(q, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      // catch any stray extra item
      repeat (50) @(posedge clock);

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
rtl/fct_pkg.sv
rtl/fct_link_ram.sv
rtl/fat_chain_table_engine.sv
tb/fat_chain_table_engine_test.sv
